[design/slbm_pkg.sv]
`default_nettype none

package slbm_pkg;

    // Bus operation codes
    typedef enum logic [1:0] {
        OP_CPU_READ  = 2'd0,
        OP_CPU_WRITE = 2'd1,
        OP_PPU_READ  = 2'd2,
        OP_PPU_WRITE = 2'd3
    } op_t;

    // Region codes
    typedef enum logic [1:0] {
        REGION_NONE    = 2'd0,
        REGION_PRG_RAM = 2'd1,
        REGION_PRG_ROM = 2'd2,
        REGION_CHR     = 2'd3
    } region_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_PRG_ROM_SIZE_LOG2 = 2'd0,
        CFG_CHR_SIZE_LOG2     = 2'd1,
        CFG_DEFAULT_MIRRORING = 2'd2,
        CFG_UNUSED            = 2'd3
    } cfg_index_t;

    // Serial loader targets, from address bits 14..13
    typedef enum logic [1:0] {
        TGT_CONTROL  = 2'd0,
        TGT_CHR_LOW  = 2'd1,
        TGT_CHR_HIGH = 2'd2,
        TGT_PROGRAM  = 2'd3
    } target_t;

    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MAP_W    = 18;
    localparam int CFG_W    = 3;

    localparam logic [4:0] SHIFT_EMPTY    = 5'h10;
    localparam logic [4:0] CONTROL_RESET  = 5'h0C;
    localparam logic [2:0] PRG_LOG2_RESET = 3'd3;
    localparam logic [2:0] CHR_LOG2_RESET = 3'd1;
    localparam logic [1:0] MIRROR_RESET   = 2'd3;
    localparam logic [2:0] PRG_LOG2_MAX   = 3'd4;
    localparam logic [2:0] CHR_LOG2_MAX   = 3'd5;

    // Program modes, control bits 3..2
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;

    typedef struct packed {
        logic [4:0] serial_shift;
        logic [4:0] control_word;
        logic [4:0] char_bank_low;
        logic [4:0] char_bank_high;
        logic [3:0] program_bank;
        logic [1:0] mirroring_mode;
    } mapper_state_t;

    typedef struct packed {
        logic [2:0] prg_log2;
        logic [2:0] chr_log2;
        logic [1:0] default_mirroring;
    } mapper_cfg_t;

    typedef struct packed {
        logic             handled;
        region_t          region;
        logic [MAP_W-1:0] mapped_address;
        logic             write_enable;
        logic [DATA_W-1:0] write_data;
        logic [1:0]       mirroring;
    } access_result_t;

endpackage

`default_nettype wire

[design/serial_loaded_bank_mapper_core.sv]
`default_nettype none
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_operation, s_address, s_data
// m_        out        m_valid / m_ready    m_handled, m_region, m_mapped_address,
//                                           m_write_enable, m_write_data, m_mirroring
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each request passes through the input register and then the result register;
// one request per cycle is sustained while m_ready stays high.
// The mapper state is read and updated once per request as it moves from the
// input register to the result register, so requests see each other in order.
// Reset is synchronous on aresetn low and restores all mapper and config state.
// A stall on m_ready holds the result register and then the input register;
// s_ready follows from that in the same cycle. cfg_ready is always high.

module serial_loaded_bank_mapper_core (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [1:0]                   s_operation,
    input  wire  [slbm_pkg::ADDR_W-1:0]  s_address,
    input  wire  [slbm_pkg::DATA_W-1:0]  s_data,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_handled,
    output logic [1:0]                   m_region,
    output logic [slbm_pkg::MAP_W-1:0]   m_mapped_address,
    output logic                         m_write_enable,
    output logic [slbm_pkg::DATA_W-1:0]  m_write_data,
    output logic [1:0]                   m_mirroring,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [1:0]                   cfg_index,
    input  wire  [slbm_pkg::CFG_W-1:0]   cfg_data
);
    import slbm_pkg::*;

    // Input register
    logic              in_valid_reg;
    logic [1:0]        op_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] data_reg;

    // Result register
    logic              out_valid_reg;
    access_result_t    result_reg;

    mapper_cfg_t       cfg;
    mapper_state_t     state;
    mapper_state_t     state_next;
    access_result_t    result_next;

    logic              out_advance;
    logic              in_advance;

    // The result register frees when empty or when the request in it is taken
    assign out_advance = !out_valid_reg || m_ready;
    // Processing moves one request from input to result register
    assign in_advance  = in_valid_reg && out_advance;
    assign s_ready     = !in_valid_reg || out_advance;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    // Load payload on acceptance only; hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_operation;
            addr_reg <= s_address;
            data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_advance) begin
            result_reg <= result_next;
        end
    end

    slbm_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_write   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .state_write (in_advance),
        .state_next  (state_next),
        .cfg         (cfg),
        .state       (state)
    );

    slbm_decode u_decode (
        .operation  (op_reg),
        .address    (addr_reg),
        .data       (data_reg),
        .cfg        (cfg),
        .state      (state),
        .state_next (state_next),
        .result     (result_next)
    );

    assign m_valid          = out_valid_reg;
    assign m_handled        = result_reg.handled;
    assign m_region         = result_reg.region;
    assign m_mapped_address = result_reg.mapped_address;
    assign m_write_enable   = result_reg.write_enable;
    assign m_write_data     = result_reg.write_data;
    assign m_mirroring      = result_reg.mirroring;

endmodule

`default_nettype wire

[design/slbm_regs.sv]
`default_nettype none

module slbm_regs (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_write,
    input  wire  [1:0]                   cfg_index,
    input  wire  [slbm_pkg::CFG_W-1:0]   cfg_data,
    input  wire                          state_write,
    input  slbm_pkg::mapper_state_t      state_next,
    output slbm_pkg::mapper_cfg_t        cfg,
    output slbm_pkg::mapper_state_t      state
);
    import slbm_pkg::*;

    mapper_cfg_t   cfg_reg;
    mapper_state_t state_reg;

    // User must do configuration changes while idle, unchecked; cfg wins.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prg_log2          <= PRG_LOG2_RESET;
            cfg_reg.chr_log2          <= CHR_LOG2_RESET;
            cfg_reg.default_mirroring <= MIRROR_RESET;
            state_reg.serial_shift    <= SHIFT_EMPTY;
            state_reg.control_word    <= CONTROL_RESET;
            state_reg.char_bank_low   <= '0;
            state_reg.char_bank_high  <= '0;
            state_reg.program_bank    <= '0;
            state_reg.mirroring_mode  <= MIRROR_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PRG_ROM_SIZE_LOG2: cfg_reg.prg_log2 <= cfg_data;
                CFG_CHR_SIZE_LOG2:     cfg_reg.chr_log2 <= cfg_data;
                CFG_DEFAULT_MIRRORING: begin
                    cfg_reg.default_mirroring <= cfg_data[1:0];
                    state_reg.mirroring_mode  <= cfg_data[1:0];
                end
                default: ;
            endcase
        end else if (state_write) begin
            state_reg <= state_next;
        end
    end

    assign cfg   = cfg_reg;
    assign state = state_reg;

endmodule

`default_nettype wire

[design/slbm_decode.sv]
`default_nettype none

module slbm_decode (
    input  wire  [1:0]                     operation,
    input  wire  [slbm_pkg::ADDR_W-1:0]    address,
    input  wire  [slbm_pkg::DATA_W-1:0]    data,
    input  slbm_pkg::mapper_cfg_t          cfg,
    input  slbm_pkg::mapper_state_t        state,
    output slbm_pkg::mapper_state_t        state_next,
    output slbm_pkg::access_result_t       result
);
    import slbm_pkg::*;

    op_t              op;
    logic [2:0]       prg_lg;
    logic [2:0]       chr_lg;
    logic [MAP_W-1:0] prg_mask;
    logic [MAP_W-1:0] chr_mask;
    logic [3:0]       prg_last;
    logic [3:0]       rom_bank;
    logic [MAP_W-1:0] prg_off;
    logic [4:0]       chr_bank;
    logic [MAP_W-1:0] chr_off;
    logic [4:0]       shift_val;
    logic             is_ram;
    logic             is_rom;
    logic             is_chr;

    assign op = op_t'(operation);

    // Clamp oversized sizes so offsets fit the output width
    assign prg_lg   = (cfg.prg_log2 > PRG_LOG2_MAX) ? PRG_LOG2_MAX : cfg.prg_log2;
    assign chr_lg   = (cfg.chr_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : cfg.chr_log2;
    assign prg_mask = ~({MAP_W{1'b1}} << (5'd14 + {2'b00, prg_lg}));
    assign chr_mask = ~({MAP_W{1'b1}} << (5'd12 + {2'b00, chr_lg}));
    assign prg_last = 4'((5'd1 << prg_lg) - 5'd1);

    always_comb begin
        rom_bank = state.program_bank;
        if (state.control_word[3:2] == PRG_MODE_FIX_FIRST) begin
            rom_bank = address[14] ? state.program_bank : 4'd0;
        end else begin
            rom_bank = address[14] ? prg_last : state.program_bank;
        end
        if (!state.control_word[3]) begin
            // 32 KiB mode: ignore the low bank bit
            prg_off = {state.program_bank[3:1], address[14:0]} & prg_mask;
        end else begin
            prg_off = {rom_bank, address[13:0]} & prg_mask;
        end
    end

    always_comb begin
        if (!state.control_word[4]) begin
            chr_bank = {state.char_bank_low[4:1], address[12]};
        end else begin
            chr_bank = address[12] ? state.char_bank_high : state.char_bank_low;
        end
        chr_off = {1'b0, chr_bank, address[11:0]} & chr_mask;
    end

    assign is_ram = (op == OP_CPU_READ || op == OP_CPU_WRITE) && address[15:13] == 3'b011;
    assign is_rom = (op == OP_CPU_READ || op == OP_CPU_WRITE) && address[15];
    assign is_chr = (op == OP_PPU_READ || op == OP_PPU_WRITE) && address[15:13] == 3'b000;

    assign shift_val = {data[0], state.serial_shift[4:1]};

    // Serial loader: only a processor write into the upper half touches it
    always_comb begin
        state_next = state;
        if (is_rom && op == OP_CPU_WRITE) begin
            if (data[7]) begin
                state_next.serial_shift = SHIFT_EMPTY;
                state_next.control_word = state.control_word | CONTROL_RESET;
            end else if (!state.serial_shift[0]) begin
                state_next.serial_shift = shift_val;
            end else begin
                state_next.serial_shift = SHIFT_EMPTY;
                unique case (target_t'(address[14:13]))
                    TGT_CONTROL: begin
                        state_next.control_word   = shift_val;
                        state_next.mirroring_mode = shift_val[1:0];
                    end
                    TGT_CHR_LOW:  state_next.char_bank_low  = shift_val;
                    TGT_CHR_HIGH: state_next.char_bank_high = shift_val;
                    TGT_PROGRAM:  state_next.program_bank   = shift_val[3:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        result                = '0;
        result.region         = REGION_NONE;
        result.mirroring      = state_next.mirroring_mode;
        result.handled        = is_ram | is_rom | is_chr;
        if (is_ram) begin
            result.region         = REGION_PRG_RAM;
            result.mapped_address = {5'd0, address[12:0]};
            result.write_enable   = (op == OP_CPU_WRITE);
        end else if (is_rom && op == OP_CPU_READ) begin
            result.region         = REGION_PRG_ROM;
            result.mapped_address = prg_off;
        end else if (is_chr) begin
            result.region         = REGION_CHR;
            result.mapped_address = chr_off;
            result.write_enable   = (op == OP_PPU_WRITE);
        end
        result.write_data = result.write_enable ? data : '0;
    end

endmodule

`default_nettype wire

[design/slbm_checker.sv]
`default_nettype none

module slbm_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire  [slbm_pkg::ADDR_W-1:0]  s_address,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire                          m_handled,
    input wire  [1:0]                   m_region,
    input wire  [slbm_pkg::MAP_W-1:0]   m_mapped_address,
    input wire                          m_write_enable,
    input wire  [slbm_pkg::DATA_W-1:0]  m_write_data
);
    import slbm_pkg::*;

    // A stalled request holds its address
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_address))
        else $error("input request changed while stalled");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mapped_address) && $stable(m_region))
        else $error("result changed while stalled");

    // Unclaimed accesses carry no region, offset or write
    a_unclaimed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_handled |->
            m_region == REGION_NONE && m_mapped_address == '0 && !m_write_enable)
        else $error("unclaimed access carries a target");

    // Write data is zero unless a write is enabled
    a_wdata: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_write_data == '0)
        else $error("write data without write enable");

    // Program ROM is never written: writes are enabled only in PRG RAM or CHR
    a_rom_ro: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_enable |->
            m_handled && (m_region == REGION_PRG_RAM || m_region == REGION_CHR))
        else $error("write enabled outside a writable region");

endmodule

bind serial_loaded_bank_mapper_core slbm_checker u_slbm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_address        (s_address),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_handled        (m_handled),
    .m_region         (m_region),
    .m_mapped_address (m_mapped_address),
    .m_write_enable   (m_write_enable),
    .m_write_data     (m_write_data)
);

`default_nettype wire
